// File: rtl/rhc_pkg.sv
// Package for the RGB/HSV converter: stage record, codes and pipeline constants.
`timescale 1ns / 1ps
`default_nettype none
package rhc_pkg;

    localparam int DIV_BITS  = 8;
    localparam int DIV_FIRST = 5;
    localparam int NST       = DIV_FIRST + DIV_BITS + 1;
    // floor(y/60) == (y * RECIP60) >> RECIP_SH for y below 16384
    localparam logic [16:0] RECIP60  = 17'd69906;
    localparam int          RECIP_SH = 22;

    localparam logic OP_RGB2HSV = 1'b0;
    localparam logic OP_HSV2RGB = 1'b1;

    typedef enum logic [1:0] {
        HB_RED,
        HB_GREEN,
        HB_BLUE
    } t_hue_base;

    typedef struct packed {
        logic        op;
        logic [8:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic        flat;
        logic        neg;
        t_hue_base   base;
        logic [7:0]  mxv;
        logic [15:0] hrem;
        logic [7:0]  hden;
        logic [7:0]  hq;
        logic [15:0] srem;
        logic [7:0]  sden;
        logic [7:0]  sq;
        logic [2:0]  sector;
        logic [5:0]  f;
        logic [15:0] prod;
        logic [7:0]  s;
        logic [13:0] ms;
        logic [13:0] mt;
        logic [7:0]  qd;
        logic [7:0]  td;
        logic [8:0]  ra;
        logic [7:0]  rb;
        logic [7:0]  rc;
    } t_item;

endpackage
`default_nettype wire

// File: rtl/rhc_if.sv
// Valid/ready channel interfaces for the converter input and result streams.
`timescale 1ns / 1ps
`default_nettype none
interface rhc_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [8:0] comp_a;
    logic [7:0] comp_b;
    logic [7:0] comp_c;
    modport source (output valid, opcode, comp_a, comp_b, comp_c, input ready);
    modport sink   (input valid, opcode, comp_a, comp_b, comp_c, output ready);
endinterface

interface rhc_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] res_a;
    logic [7:0] res_b;
    logic [7:0] res_c;
    modport source (output valid, res_a, res_b, res_c, input ready);
    modport sink   (input valid, res_a, res_b, res_c, output ready);
endinterface
`default_nettype wire

// File: rtl/rgb_hsv_color_converter.sv
// Throughput: one transaction per cycle unless o_out stalls; each of the 14 stages
// advances when it is empty or its successor advances, so bubbles close up under stall.
// Hue and saturation come from an 8-stage restoring divider, one bit a stage.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps
`default_nettype none
module rgb_hsv_color_converter
    import rhc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    rhc_in_if.sink     i_in,
    rhc_out_if.source  o_out
);

    t_item            r_pipe [NST];
    t_item            n_pipe [NST];
    logic [NST-1:0]   r_vld;
    logic [NST-1:0]   stage_en;

    always_comb begin
        stage_en[NST-1] = !r_vld[NST-1] || o_out.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign i_in.ready  = stage_en[0];
    assign o_out.valid = r_vld[NST-1];
    assign o_out.res_a = r_pipe[NST-1].ra;
    assign o_out.res_b = r_pipe[NST-1].rb;
    assign o_out.res_c = r_pipe[NST-1].rc;

    always_comb begin
        logic [7:0]        red, mx, mn, chroma, mag, pv, qv, tv;
        logic signed [8:0] diff;
        logic [3:0]        q8;
        logic [16:0]       sum;
        logic [30:0]       wq, wt;
        logic [15:0]       cmp;
        logic signed [10:0] hue;
        int                bitn;

        n_pipe[0]   = '0;
        n_pipe[0].op = i_in.opcode;
        n_pipe[0].a  = i_in.comp_a;
        n_pipe[0].b  = i_in.comp_b;
        n_pipe[0].c  = i_in.comp_c;

        // prep: min/max and dividend setup, or HSV product and sector split
        n_pipe[1] = r_pipe[0];
        red = r_pipe[0].a[7:0];
        mx = red;
        mn = red;
        if (r_pipe[0].b > mx) mx = r_pipe[0].b;
        if (r_pipe[0].c > mx) mx = r_pipe[0].c;
        if (r_pipe[0].b < mn) mn = r_pipe[0].b;
        if (r_pipe[0].c < mn) mn = r_pipe[0].c;
        chroma = mx - mn;
        if (red == mx) begin
            diff = $signed({1'b0, r_pipe[0].b}) - $signed({1'b0, r_pipe[0].c});
            n_pipe[1].base = HB_RED;
        end else if (r_pipe[0].b == mx) begin
            diff = $signed({1'b0, r_pipe[0].c}) - $signed({1'b0, red});
            n_pipe[1].base = HB_GREEN;
        end else begin
            diff = $signed({1'b0, red}) - $signed({1'b0, r_pipe[0].b});
            n_pipe[1].base = HB_BLUE;
        end
        mag = diff[8] ? 8'(-diff) : diff[7:0];
        n_pipe[1].neg  = diff[8];
        n_pipe[1].mxv  = mx;
        n_pipe[1].hrem = 16'(mag) * 16'd60;
        n_pipe[1].hden = chroma;
        n_pipe[1].hq   = '0;
        n_pipe[1].srem = {chroma, 8'd0} - 16'(chroma);
        n_pipe[1].sden = mx;
        n_pipe[1].sq   = '0;
        n_pipe[1].flat = (r_pipe[0].op == OP_HSV2RGB) ? (r_pipe[0].b == 8'd0) : (mx == mn);
        n_pipe[1].prod = 16'(r_pipe[0].c) * 16'(r_pipe[0].b);
        q8 = '0;
        for (int j = 1; j <= 8; j++) begin
            if (r_pipe[0].a >= 9'(60 * j)) q8 = 4'(j);
        end
        n_pipe[1].sector = (q8 > 4'd5) ? 3'd5 : q8[2:0];
        n_pipe[1].f = 6'(r_pipe[0].a - 9'(q8 * 60));

        // s = floor(v*sat/255)
        n_pipe[2] = r_pipe[1];
        sum = 17'(r_pipe[1].prod) + 17'(r_pipe[1].prod[15:8]) + 17'd1;
        n_pipe[2].s = sum[15:8];

        n_pipe[3] = r_pipe[2];
        n_pipe[3].ms = 14'(r_pipe[2].s) * 14'(r_pipe[2].f);
        n_pipe[3].mt = 14'(r_pipe[2].s) * 14'(6'd60 - r_pipe[2].f);

        n_pipe[4] = r_pipe[3];
        wq = 31'(r_pipe[3].ms) * 31'(RECIP60);
        wt = 31'(r_pipe[3].mt) * 31'(RECIP60);
        n_pipe[4].qd = 8'(wq >> RECIP_SH);
        n_pipe[4].td = 8'(wt >> RECIP_SH);

        // divider bit stages; the first also finishes the HSV path
        for (int k = DIV_FIRST; k < DIV_FIRST + DIV_BITS; k++) begin
            n_pipe[k] = r_pipe[k-1];
            bitn = DIV_BITS - 1 - (k - DIV_FIRST);
            cmp = 16'(r_pipe[k-1].hden) << bitn;
            if (r_pipe[k-1].hrem >= cmp) begin
                n_pipe[k].hrem = r_pipe[k-1].hrem - cmp;
                n_pipe[k].hq[bitn] = 1'b1;
            end
            cmp = 16'(r_pipe[k-1].sden) << bitn;
            if (r_pipe[k-1].srem >= cmp) begin
                n_pipe[k].srem = r_pipe[k-1].srem - cmp;
                n_pipe[k].sq[bitn] = 1'b1;
            end
        end
        pv = r_pipe[DIV_FIRST-1].c - r_pipe[DIV_FIRST-1].s;
        qv = r_pipe[DIV_FIRST-1].c - r_pipe[DIV_FIRST-1].qd;
        tv = r_pipe[DIV_FIRST-1].c - r_pipe[DIV_FIRST-1].td;
        if (r_pipe[DIV_FIRST-1].flat) begin
            n_pipe[DIV_FIRST].ra = {1'b0, r_pipe[DIV_FIRST-1].c};
            n_pipe[DIV_FIRST].rb = r_pipe[DIV_FIRST-1].c;
            n_pipe[DIV_FIRST].rc = r_pipe[DIV_FIRST-1].c;
        end else begin
            case (r_pipe[DIV_FIRST-1].sector)
                3'd0: begin
                    n_pipe[DIV_FIRST].ra = {1'b0, r_pipe[DIV_FIRST-1].c};
                    n_pipe[DIV_FIRST].rb = tv;
                    n_pipe[DIV_FIRST].rc = pv;
                end
                3'd1: begin
                    n_pipe[DIV_FIRST].ra = {1'b0, qv};
                    n_pipe[DIV_FIRST].rb = r_pipe[DIV_FIRST-1].c;
                    n_pipe[DIV_FIRST].rc = pv;
                end
                3'd2: begin
                    n_pipe[DIV_FIRST].ra = {1'b0, pv};
                    n_pipe[DIV_FIRST].rb = r_pipe[DIV_FIRST-1].c;
                    n_pipe[DIV_FIRST].rc = tv;
                end
                3'd3: begin
                    n_pipe[DIV_FIRST].ra = {1'b0, pv};
                    n_pipe[DIV_FIRST].rb = qv;
                    n_pipe[DIV_FIRST].rc = r_pipe[DIV_FIRST-1].c;
                end
                3'd4: begin
                    n_pipe[DIV_FIRST].ra = {1'b0, tv};
                    n_pipe[DIV_FIRST].rb = pv;
                    n_pipe[DIV_FIRST].rc = r_pipe[DIV_FIRST-1].c;
                end
                default: begin
                    n_pipe[DIV_FIRST].ra = {1'b0, r_pipe[DIV_FIRST-1].c};
                    n_pipe[DIV_FIRST].rb = pv;
                    n_pipe[DIV_FIRST].rc = qv;
                end
            endcase
        end

        // final: signed hue with sector offset and wrap
        n_pipe[NST-1] = r_pipe[NST-2];
        hue = r_pipe[NST-2].neg ? -$signed({3'b0, r_pipe[NST-2].hq})
                                :  $signed({3'b0, r_pipe[NST-2].hq});
        case (r_pipe[NST-2].base)
            HB_GREEN: hue = hue + 11'sd120;
            HB_BLUE:  hue = hue + 11'sd240;
            default:  hue = hue;
        endcase
        if (hue < 0) hue = hue + 11'sd360;
        if (r_pipe[NST-2].op == OP_RGB2HSV) begin
            n_pipe[NST-1].rc = r_pipe[NST-2].mxv;
            if (r_pipe[NST-2].flat) begin
                n_pipe[NST-1].ra = '0;
                n_pipe[NST-1].rb = '0;
            end else begin
                n_pipe[NST-1].ra = hue[8:0];
                n_pipe[NST-1].rb = r_pipe[NST-2].sq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) r_vld[0] <= i_in.valid;
            for (int k = 1; k < NST; k++) begin
                if (stage_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // advance payload only where the stage moves
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (stage_en[k]) r_pipe[k] <= n_pipe[k];
        end
    end

endmodule
`default_nettype wire
